// File: rtl/core/spdc_pkg.sv
// Shared types and constants for the serial packet deframer with CRC check.
`timescale 1ns / 1ps

package spdc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

    localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'hff;

    typedef enum logic [1:0] {
        PS_OK       = 2'd0,
        PS_MISMATCH = 2'd1,
        PS_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              has_byte;
        logic              end_of_packet;
        t_status           status;
    } t_result;

endpackage

// File: rtl/core/spdc_frame_ctl.sv
// Header hunt, body counting and CRC-16 update for one staged byte per cycle while i_step is high.
`timescale 1ns / 1ps

module spdc_frame_ctl import spdc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef enum logic [5:0] {
        ST_SYNC1 = 6'b000001,
        ST_SYNC2 = 6'b000010,
        ST_LEN   = 6'b000100,
        ST_HCHK  = 6'b001000,
        ST_BCHK  = 6'b010000,
        ST_BODY  = 6'b100000
    } t_state;

    t_state            r_state,     n_state;
    logic [BYTE_W-1:0] r_body_len,  n_body_len;
    logic [BYTE_W-1:0] r_exp_check, n_exp_check;
    logic [BYTE_W-1:0] r_body_cnt,  n_body_cnt;
    logic [CRC_W-1:0]  r_crc,       n_crc;

    logic [CRC_W-1:0]  w_crc_next;
    logic [BYTE_W-1:0] w_hdr_sum;
    logic              w_last;

    // MSB-first CRC over one byte; eight shift steps unroll into XOR logic.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    // The check byte is tested first; the length limit only matters on a good CRC.
    function automatic t_status end_status(input logic [CRC_W-1:0]  crc,
                                           input logic [BYTE_W-1:0] check,
                                           input logic [BYTE_W-1:0] len,
                                           input logic [BYTE_W-1:0] max_len);
        t_status s;
        if (crc[BYTE_W-1:0] != check) begin
            s = PS_MISMATCH;
        end else if (len > max_len) begin
            s = PS_TOO_LONG;
        end else begin
            s = PS_OK;
        end
        return s;
    endfunction

    assign w_crc_next = crc_feed(r_crc, i_byte);
    assign w_hdr_sum  = i_cfg.sync_first + i_cfg.sync_second + r_body_len;
    assign w_last     = ({1'b0, r_body_cnt} + 9'd1) == {1'b0, r_body_len};

    always_comb begin
        n_state     = r_state;
        n_body_len  = r_body_len;
        n_exp_check = r_exp_check;
        n_body_cnt  = r_body_cnt;
        n_crc       = r_crc;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_step) begin
            case (r_state)
                ST_SYNC1: begin
                    if (i_byte == i_cfg.sync_first) begin
                        n_state = ST_SYNC2;
                    end
                end
                ST_SYNC2: begin
                    n_state = (i_byte == i_cfg.sync_second) ? ST_LEN : ST_SYNC1;
                end
                ST_LEN: begin
                    n_body_len = i_byte;
                    n_state    = ST_HCHK;
                end
                ST_HCHK: begin
                    n_state = (i_byte == w_hdr_sum) ? ST_BCHK : ST_SYNC1;
                end
                ST_BCHK: begin
                    n_exp_check = i_byte;
                    n_crc       = '0;
                    n_body_cnt  = '0;
                    if (r_body_len == '0) begin
                        // An empty body still closes the packet with a status.
                        o_res_valid         = 1'b1;
                        o_res.end_of_packet = 1'b1;
                        o_res.status        = end_status('0, i_byte, r_body_len,
                                                         i_cfg.max_len);
                        n_state             = ST_SYNC1;
                    end else begin
                        n_state = ST_BODY;
                    end
                end
                ST_BODY: begin
                    n_crc           = w_crc_next;
                    o_res_valid     = 1'b1;
                    o_res.body_byte = i_byte;
                    o_res.has_byte  = 1'b1;
                    if (w_last) begin
                        o_res.end_of_packet = 1'b1;
                        o_res.status        = end_status(w_crc_next, r_exp_check,
                                                         r_body_len, i_cfg.max_len);
                        n_state             = ST_SYNC1;
                    end else begin
                        n_body_cnt = r_body_cnt + 8'd1;
                    end
                end
                default: begin
                    n_state = ST_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SYNC1;
            r_body_len  <= '0;
            r_exp_check <= '0;
            r_body_cnt  <= '0;
            r_crc       <= '0;
        end else begin
            r_state     <= n_state;
            r_body_len  <= n_body_len;
            r_exp_check <= n_exp_check;
            r_body_cnt  <= n_body_cnt;
            r_crc       <= n_crc;
        end
    end

`ifndef SYNTH
    a_res_only_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_state == ST_BCHK || r_state == ST_BODY))
        else $error("result raised outside check byte or body phase");

    a_cnt_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BODY) |-> (r_body_cnt < r_body_len))
        else $error("body counter ran past the header length");

    a_eop_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.end_of_packet) |=> (r_state == ST_SYNC1))
        else $error("packet end did not restart the header hunt");
`endif

endmodule

// File: rtl/core/spdc_out_stage.sv
// Result register that holds one finished result until downstream takes it.
`timescale 1ns / 1ps

module spdc_out_stage import spdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result leaves at this edge.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/core/serial_packet_deframer_crc_check.sv
// Top level of the serial packet deframer: input register, config registers, result register.
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_ready   i_rx_byte
//  out       source     o_out_valid / i_out_ready o_body_byte, o_has_byte,
//                                                 o_end_of_packet, o_packet_status
//  cfg       sink       i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One byte is taken per cycle while o_in_ready is high. An accepted byte waits in the
// input register until the result register is free; body bytes and packet ends give a result.
// The CRC-16 byte update is eight unrolled XOR steps between those two registers.
// Reset is synchronous and puts the block back into the header hunt.
// When the result register is full and not taken, the input register holds its
// byte and o_in_ready drops until room opens.
`timescale 1ns / 1ps

module serial_packet_deframer_crc_check import spdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_body_byte,
    output logic                 o_has_byte,
    output logic                 o_end_of_packet,
    output logic [1:0]           o_packet_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic    w_out_free;
    logic    w_adv;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= '0;
            r_cfg.sync_second <= '0;
            r_cfg.max_len     <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                CFG_MAX_LEN:     r_cfg.max_len     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The staged byte moves on whenever the result register can take a result.
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    spdc_frame_ctl u_frame_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (w_adv),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    spdc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_ready (i_out_ready),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_res   (w_out_res)
    );

    assign o_body_byte     = w_out_res.body_byte;
    assign o_has_byte      = w_out_res.has_byte;
    assign o_end_of_packet = w_out_res.end_of_packet;
    assign o_packet_status = w_out_res.status;

`ifndef SYNTH
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_byte) |-> o_end_of_packet)
        else $error("result without a body byte must close a packet");

    a_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_end_of_packet) |-> (o_packet_status == PS_OK))
        else $error("status raised on a mid-packet result");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("staged byte lost while the result register was full");
`endif

endmodule
